// ----- design/htw_pkg.sv -----
`default_nettype none

package htw_pkg;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int CONN_W    = 6;
    localparam int TIMEOUT_W = 16;
    localparam int INTV_W    = 8;
    localparam int ROUNDS_W  = 10;

    // Wheel geometry; SLOTS is a power of two so slot arithmetic wraps naturally
    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int TIMERS  = 64;
    localparam int TIMER_W = $clog2(TIMERS);
    localparam int SCAN_W  = TIMER_W + 1;

    localparam int ROUNDS_MAX = (2 ** ROUNDS_W) - 1;
    localparam int DIV_CNT_W  = $clog2(TIMEOUT_W + 1);

    localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(1);

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DEL  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TICK = 2'd2;

    // Result status codes
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_TIMER = 1'b1;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [ROUNDS_W-1:0] rounds;
    } entry_t;

    // Timer table access for one cycle
    typedef struct packed {
        logic               re;
        logic [TIMER_W-1:0] raddr;
        logic               we;
        logic [TIMER_W-1:0] waddr;
        entry_t             wentry;
        logic               arm_set;
        logic               arm_clr;
        logic [TIMER_W-1:0] arm_idx;
    } tbl_cmd_t;

endpackage

`default_nettype wire

// ----- design/htw_ifs.sv -----
`default_nettype none

interface htw_in_if import htw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [CONN_W-1:0]    conn_id;
    logic [TIMEOUT_W-1:0] timeout;

    modport source (output valid, output func, output conn_id, output timeout,
                    input ready);
    modport sink   (input valid, input func, input conn_id, input timeout,
                    output ready);
endinterface

interface htw_out_if import htw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CONN_W-1:0] expired_conn;
    logic              expired;
    logic              last;
    logic              status;

    modport source (output valid, output expired_conn, output expired, output last,
                    output status, input ready);
    modport sink   (input valid, input expired_conn, input expired, input last,
                    input status, output ready);
endinterface

interface htw_cfg_if import htw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [INTV_W-1:0] intv_data;

    modport source (output valid, output intv_data, input ready);
    modport sink   (input valid, input intv_data, output ready);
endinterface

`default_nettype wire

// ----- design/htw_div.sv -----
`default_nettype none

module htw_div import htw_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TIMEOUT_W-1:0] dividend,
    input  logic [INTV_W-1:0]    divisor,
    output logic                 done,
    output logic [TIMEOUT_W-1:0] quotient
);

    logic [TIMEOUT_W-1:0] quo_reg, quo_next;
    logic [INTV_W-1:0]    rem_reg, rem_next;
    logic [INTV_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [INTV_W:0]      rem_sh;
    logic [INTV_W:0]      rem_sub;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[TIMEOUT_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        fits     = (rem_sh >= {1'b0, dvs_reg});
        rem_next = fits ? rem_sub[INTV_W-1:0] : rem_sh[INTV_W-1:0];
        quo_next = {quo_reg[TIMEOUT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= DIV_CNT_W'(TIMEOUT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- design/htw_table.sv -----
`default_nettype none

module htw_table import htw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_cmd_t          cmd,
    output entry_t            rd_entry,
    output logic [TIMERS-1:0] armed
);

    entry_t            mem [TIMERS];
    entry_t            rd_entry_reg;
    logic [TIMERS-1:0] armed_reg;

    // Slot and rounds store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wentry;
        end
        if (cmd.re)
        begin
            rd_entry_reg <= mem[cmd.raddr];
        end
    end

    // Armed flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= '0;
        end
        else if (cmd.arm_set)
        begin
            armed_reg[cmd.arm_idx] <= 1'b1;
        end
        else if (cmd.arm_clr)
        begin
            armed_reg[cmd.arm_idx] <= 1'b0;
        end
    end

    assign rd_entry = rd_entry_reg;
    assign armed    = armed_reg;

endmodule

`default_nettype wire

// ----- design/hashed_timing_wheel.sv -----
`default_nettype none

// Hashed timing wheel, one timer per connection.
// cfg: write channel for the slot interval (timeout units per slot), always
//   ready; write it only while the block is idle. Zero acts as one.
// req: operations add (conn_id, timeout), delete (conn_id) and tick.
// rsp: one transfer per add, delete or unused code; a tick gives one
//   transfer per expired timer in ascending connection order, or a single
//   empty transfer, with last set on the final one.
// Sequencing: req is taken only in the idle state. An add waits on the
//   bit-serial divider (16 steps) before its entry is written. A delete
//   answers directly. A tick sweeps the timer table's single read port
//   one entry per cycle while rsp does not stall.
// A finished result sits in the rsp output register; the next request is
//   accepted while it waits. When rsp stalls during a tick, the scan holds
//   until the pending expiry can move into the output register.
// Reset: the slot interval returns to 1, the current slot to 0 and every timer
//   is disarmed at once; the block is ready in the first cycle after reset.
module hashed_timing_wheel import htw_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    htw_cfg_if.sink      cfg,
    htw_in_if.sink       req,
    htw_out_if.source    rsp
);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_RESP, S_SCAN, S_FIN} state_t;

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    wheel_pos_reg, wheel_pos_next;
    logic [INTV_W-1:0]    intv_reg, intv_next;
    logic [TIMER_W-1:0]   conn_reg, conn_next;
    logic                 st_reg, st_next;
    logic [SCAN_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                 ev_vld_reg, ev_vld_next;
    logic [TIMER_W-1:0]   ev_idx_reg, ev_idx_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [TIMER_W-1:0]   pend_idx_reg, pend_idx_next;
    logic                 rsp_vld_reg, rsp_vld_next;
    logic [CONN_W-1:0]    rsp_conn_reg, rsp_conn_next;
    logic                 rsp_exp_reg, rsp_exp_next;
    logic                 rsp_last_reg, rsp_last_next;
    logic                 rsp_st_reg, rsp_st_next;

    logic                 req_fire;
    logic                 can_push;
    logic                 push_en;
    logic [CONN_W-1:0]    push_conn;
    logic                 push_exp;
    logic                 push_last;
    logic                 push_st;

    logic                 div_start;
    logic                 div_done;
    logic [TIMEOUT_W-1:0] div_quo;
    logic [INTV_W-1:0]    divisor;

    tbl_cmd_t             cmd;
    entry_t               rd_entry;
    logic [TIMERS-1:0]    armed;

    logic [TIMEOUT_W-1:0] ticks;
    logic [TIMEOUT_W-1:0] rounds_full;
    logic [ROUNDS_W-1:0]  rounds_sat;
    logic                 conn_ok;
    logic                 hit;
    logic                 expire;
    logic                 stall;

    htw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.timeout),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    htw_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_entry (rd_entry),
        .armed    (armed)
    );

    assign req_fire = req.valid && req.ready;
    assign can_push = !rsp_vld_reg || rsp.ready;
    assign divisor  = (intv_reg == '0) ? INTV_W'(1) : intv_reg;
    assign conn_ok  = ({1'b0, req.conn_id} < (CONN_W + 1)'(TIMERS));

    // Turn the quotient into ticks and saturated rounds
    always_comb
    begin
        ticks       = (div_quo == '0) ? TIMEOUT_W'(1) : div_quo;
        rounds_full = ticks >> SLOT_W;
        rounds_sat  = (rounds_full > TIMEOUT_W'(ROUNDS_MAX)) ?
                      ROUNDS_W'(ROUNDS_MAX) : rounds_full[ROUNDS_W-1:0];
    end

    // Evaluate the entry last read from the table
    assign hit    = ev_vld_reg && armed[ev_idx_reg] && (rd_entry.slot == wheel_pos_reg);
    assign expire = hit && (rd_entry.rounds == '0);
    assign stall  = expire && pend_vld_reg && !can_push;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        wheel_pos_next = wheel_pos_reg;
        intv_next      = intv_reg;
        conn_next      = conn_reg;
        st_next        = st_reg;
        rd_idx_next    = rd_idx_reg;
        ev_vld_next    = ev_vld_reg;
        ev_idx_next    = ev_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        div_start      = 1'b0;
        cmd            = '0;
        push_en        = 1'b0;
        push_conn      = '0;
        push_exp       = 1'b0;
        push_last      = 1'b1;
        push_st        = ST_OK;

        if (cfg.valid && cfg.ready)
        begin
            intv_next = cfg.intv_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.func)
                        FN_ADD:
                        begin
                            st_next = ST_OK;
                            if (conn_ok)
                            begin
                                div_start  = 1'b1;
                                conn_next  = req.conn_id[TIMER_W-1:0];
                                state_next = S_DIV;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        FN_DEL:
                        begin
                            if (conn_ok && armed[req.conn_id[TIMER_W-1:0]])
                            begin
                                cmd.arm_clr = 1'b1;
                                cmd.arm_idx = req.conn_id[TIMER_W-1:0];
                                st_next     = ST_OK;
                            end
                            else
                            begin
                                st_next = ST_NO_TIMER;
                            end
                            state_next = S_RESP;
                        end
                        FN_TICK:
                        begin
                            rd_idx_next   = '0;
                            ev_vld_next   = 1'b0;
                            pend_vld_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default:
                        begin
                            st_next    = ST_OK;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    cmd.we            = 1'b1;
                    cmd.waddr         = conn_reg;
                    cmd.wentry.slot   = wheel_pos_reg + ticks[SLOT_W-1:0];
                    cmd.wentry.rounds = rounds_sat;
                    cmd.arm_set       = 1'b1;
                    cmd.arm_idx       = conn_reg;
                    state_next        = S_RESP;
                end
            end
            S_RESP:
            begin
                if (can_push)
                begin
                    push_en    = 1'b1;
                    push_st    = st_reg;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!stall)
                begin
                    // Update the evaluated entry
                    if (hit && !expire)
                    begin
                        cmd.we            = 1'b1;
                        cmd.waddr         = ev_idx_reg;
                        cmd.wentry.slot   = rd_entry.slot;
                        cmd.wentry.rounds = rd_entry.rounds - ROUNDS_W'(1);
                    end
                    if (expire)
                    begin
                        cmd.arm_clr = 1'b1;
                        cmd.arm_idx = ev_idx_reg;
                        if (pend_vld_reg)
                        begin
                            push_en   = 1'b1;
                            push_conn = CONN_W'(pend_idx_reg);
                            push_exp  = 1'b1;
                            push_last = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = ev_idx_reg;
                    end
                    // Advance the read sweep
                    if (rd_idx_reg < SCAN_W'(TIMERS))
                    begin
                        cmd.re      = 1'b1;
                        cmd.raddr   = rd_idx_reg[TIMER_W-1:0];
                        ev_vld_next = 1'b1;
                        ev_idx_next = rd_idx_reg[TIMER_W-1:0];
                        rd_idx_next = rd_idx_reg + SCAN_W'(1);
                    end
                    else
                    begin
                        ev_vld_next = 1'b0;
                        if (!ev_vld_reg)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_FIN:
            begin
                if (can_push)
                begin
                    push_en = 1'b1;
                    if (pend_vld_reg)
                    begin
                        push_conn = CONN_W'(pend_idx_reg);
                        push_exp  = 1'b1;
                    end
                    pend_vld_next  = 1'b0;
                    wheel_pos_next = wheel_pos_reg + SLOT_W'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: drop on transfer, load on push
    always_comb
    begin
        rsp_vld_next  = rsp_vld_reg && !rsp.ready;
        rsp_conn_next = rsp_conn_reg;
        rsp_exp_next  = rsp_exp_reg;
        rsp_last_next = rsp_last_reg;
        rsp_st_next   = rsp_st_reg;
        if (push_en)
        begin
            rsp_vld_next  = 1'b1;
            rsp_conn_next = push_conn;
            rsp_exp_next  = push_exp;
            rsp_last_next = push_last;
            rsp_st_next   = push_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wheel_pos_reg <= '0;
            intv_reg      <= INTV_RESET;
            conn_reg      <= '0;
            st_reg        <= ST_OK;
            rd_idx_reg    <= '0;
            ev_vld_reg    <= 1'b0;
            ev_idx_reg    <= '0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            rsp_vld_reg   <= 1'b0;
            rsp_conn_reg  <= '0;
            rsp_exp_reg   <= 1'b0;
            rsp_last_reg  <= 1'b0;
            rsp_st_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            wheel_pos_reg <= wheel_pos_next;
            intv_reg      <= intv_next;
            conn_reg      <= conn_next;
            st_reg        <= st_next;
            rd_idx_reg    <= rd_idx_next;
            ev_vld_reg    <= ev_vld_next;
            ev_idx_reg    <= ev_idx_next;
            pend_vld_reg  <= pend_vld_next;
            pend_idx_reg  <= pend_idx_next;
            rsp_vld_reg   <= rsp_vld_next;
            rsp_conn_reg  <= rsp_conn_next;
            rsp_exp_reg   <= rsp_exp_next;
            rsp_last_reg  <= rsp_last_next;
            rsp_st_reg    <= rsp_st_next;
        end
    end

    assign cfg.ready        = 1'b1;
    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_vld_reg;
    assign rsp.expired_conn = rsp_conn_reg;
    assign rsp.expired      = rsp_exp_reg;
    assign rsp.last         = rsp_last_reg;
    assign rsp.status       = rsp_st_reg;

    // The wheel only turns when a tick finishes
    a_slot_turns_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(wheel_pos_reg) |-> $past(state_reg) == S_FIN)
        else $error("current slot moved outside tick completion");

    // No expiry may be held over between operations
    a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_vld_reg)
        else $error("pending expiry left after tick");

    // Divider finishes only while an add waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside add");

    // Evaluated entry trails the read pointer by one
    a_scan_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && ev_vld_reg |->
            ({1'b0, ev_idx_reg} + SCAN_W'(1)) == rd_idx_reg)
        else $error("scan pipeline out of step");

    // An expiry never carries a delete status
    a_expiry_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && rsp_exp_reg |-> rsp_st_reg == ST_OK)
        else $error("expiry result with error status");

endmodule

`default_nettype wire
